// ----- hdl/kag_pkg.sv -----
// kag_pkg: shared types, constants and microcode encodings for the k-arrangement generator.
// Used by every module under hdl; depends on nothing else.
package kag_pkg;

	localparam int MAX_SET_DEF    = 16;
	localparam int VALUE_BITS_DEF = 8;

	localparam int IDX_W        = 5;
	localparam int PTR_W        = 5;
	localparam int POS_W        = 4;
	localparam int VAL_W        = 8;
	localparam int CFG_W        = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int RESULT_LIMIT = 16;
	localparam int IA_AW        = $clog2(RESULT_LIMIT);
	localparam int PC_W         = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT = 1'b1;

	localparam logic [CFG_W-1:0] SET_SIZE_RST   = 5'd5;
	localparam logic [CFG_W-1:0] PICK_COUNT_RST = 5'd3;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_NEXT  = 2'd2;

	// pointer operations
	localparam logic [2:0] P_HOLD = 3'd0;
	localparam logic [2:0] P_ONE  = 3'd1;
	localparam logic [2:0] P_KM1  = 3'd2;
	localparam logic [2:0] P_K    = 3'd3;
	localparam logic [2:0] P_INC  = 3'd4;
	localparam logic [2:0] P_DEC  = 3'd5;

	localparam logic [2:0] Q_HOLD = 3'd0;
	localparam logic [2:0] Q_K    = 3'd1;
	localparam logic [2:0] Q_P1   = 3'd2;
	localparam logic [2:0] Q_INC  = 3'd3;
	localparam logic [2:0] Q_DEC  = 3'd4;

	// address selects
	localparam logic [1:0] SEL_P  = 2'd0;
	localparam logic [1:0] SEL_Q  = 2'd1;
	localparam logic [1:0] SEL_P1 = 2'd2;

	// write data selects
	localparam logic [1:0] WD_P      = 2'd0;
	localparam logic [1:0] WD_RA     = 2'd1;
	localparam logic [1:0] WD_RB     = 2'd2;
	localparam logic [1:0] WD_RA_INC = 2'd3;

	// branch conditions
	localparam logic [3:0] C_NEVER     = 4'd0;
	localparam logic [3:0] C_ALWAYS    = 4'd1;
	localparam logic [3:0] C_DISPATCH  = 4'd2;
	localparam logic [3:0] C_P_NE_K    = 4'd3;
	localparam logic [3:0] C_P_EQ_K    = 4'd4;
	localparam logic [3:0] C_DONE      = 4'd5;
	localparam logic [3:0] C_P_ZERO    = 4'd6;
	localparam logic [3:0] C_RA_LE_RB  = 4'd7;
	localparam logic [3:0] C_RA_LT_RB  = 4'd8;
	localparam logic [3:0] C_P_GE_Q    = 4'd9;
	localparam logic [3:0] C_RA_NE_LIM = 4'd10;
	localparam logic [3:0] C_Q_GT_K    = 4'd11;

	// control store addresses
	localparam logic [PC_W-1:0] PC_IDLE    = 6'd0;
	localparam logic [PC_W-1:0] PC_START   = 6'd1;
	localparam logic [PC_W-1:0] PC_FILL    = 6'd2;
	localparam logic [PC_W-1:0] PC_EMIT    = 6'd3;
	localparam logic [PC_W-1:0] PC_E_RD    = 6'd4;
	localparam logic [PC_W-1:0] PC_E_TBL   = 6'd5;
	localparam logic [PC_W-1:0] PC_E_OUT   = 6'd6;
	localparam logic [PC_W-1:0] PC_E_ADV   = 6'd7;
	localparam logic [PC_W-1:0] PC_EXH     = 6'd8;
	localparam logic [PC_W-1:0] PC_NEXT    = 6'd9;
	localparam logic [PC_W-1:0] PC_N_RD    = 6'd10;
	localparam logic [PC_W-1:0] PC_N_CMP   = 6'd11;
	localparam logic [PC_W-1:0] PC_N_DEC   = 6'd12;
	localparam logic [PC_W-1:0] PC_N_QK    = 6'd13;
	localparam logic [PC_W-1:0] PC_N_QRD   = 6'd14;
	localparam logic [PC_W-1:0] PC_N_QCMP  = 6'd15;
	localparam logic [PC_W-1:0] PC_N_SWP0  = 6'd16;
	localparam logic [PC_W-1:0] PC_N_SWP1  = 6'd17;
	localparam logic [PC_W-1:0] PC_R_RD    = 6'd18;
	localparam logic [PC_W-1:0] PC_R_WP    = 6'd19;
	localparam logic [PC_W-1:0] PC_R_WQ    = 6'd20;
	localparam logic [PC_W-1:0] PC_N_QDEC  = 6'd21;
	localparam logic [PC_W-1:0] PC_F_INIT  = 6'd22;
	localparam logic [PC_W-1:0] PC_F_RD    = 6'd23;
	localparam logic [PC_W-1:0] PC_F_WP    = 6'd24;
	localparam logic [PC_W-1:0] PC_F_WQ    = 6'd25;
	localparam logic [PC_W-1:0] PC_COMB    = 6'd26;
	localparam logic [PC_W-1:0] PC_C_RD    = 6'd27;
	localparam logic [PC_W-1:0] PC_C_CMP   = 6'd28;
	localparam logic [PC_W-1:0] PC_C_DEC   = 6'd29;
	localparam logic [PC_W-1:0] PC_C_BUMP  = 6'd30;
	localparam logic [PC_W-1:0] PC_C_CHK   = 6'd31;
	localparam logic [PC_W-1:0] PC_C_FILL  = 6'd32;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] load_index;
		logic [VAL_W-1:0] load_value;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [IDX_W-1:0] element_index;
		logic [VAL_W-1:0] element_value;
		logic             last;
		logic             exhausted;
	} res_t;

	typedef struct packed {
		logic [2:0]      p_op;
		logic [2:0]      q_op;
		logic            rd_a_en;
		logic [1:0]      rd_a_sel;
		logic            rd_b_en;
		logic [1:0]      rd_b_sel;
		logic            ra_bump;
		logic            wr_en;
		logic [1:0]      wr_addr_sel;
		logic [1:0]      wr_data_sel;
		logic            tbl_rd;
		logic            run_load;
		logic            done_clr;
		logic            done_set;
		logic            out_load;
		logic            out_exh;
		logic            wait_out;
		logic [3:0]      cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic done;
		logic slot_free;
		logic p_eq_k;
		logic p_zero;
		logic ra_gt_rb;
		logic ra_lt_rb;
		logic p_ge_q;
		logic ra_eq_lim;
		logic q_gt_k;
	} dp_status_t;

	localparam ctrl_word_t CW_NOP = '0;

	function automatic logic [IA_AW-1:0] ptr_addr(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] t;
		t = ptr - PTR_W'(1);
		return t[IA_AW-1:0];
	endfunction

endpackage

// ----- hdl/kag_ucode_rom.sv -----
// kag_ucode_rom: read-only control store, one control word per sequencer step.
// Depends on kag_pkg for the control word layout and step addresses.
module kag_ucode_rom (
	input  logic [kag_pkg::PC_W-1:0] pc,
	output kag_pkg::ctrl_word_t      cw
);
	import kag_pkg::*;

	always_comb begin
		cw = CW_NOP;
		case (pc)
			PC_IDLE: begin
				cw.cond = C_DISPATCH;
			end
			PC_START: begin
				cw.run_load = 1'b1;
				cw.done_clr = 1'b1;
				cw.p_op     = P_ONE;
			end
			PC_FILL: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_P;
				cw.wr_data_sel = WD_P;
				cw.p_op        = P_INC;
				cw.cond        = C_P_NE_K;
				cw.target      = PC_FILL;
			end
			PC_EMIT: begin
				cw.p_op = P_ONE;
			end
			PC_E_RD: begin
				cw.rd_a_en  = 1'b1;
				cw.rd_a_sel = SEL_P;
			end
			PC_E_TBL: begin
				cw.tbl_rd = 1'b1;
			end
			PC_E_OUT: begin
				cw.wait_out = 1'b1;
				cw.out_load = 1'b1;
				cw.cond     = C_P_EQ_K;
				cw.target   = PC_IDLE;
			end
			PC_E_ADV: begin
				cw.p_op   = P_INC;
				cw.cond   = C_ALWAYS;
				cw.target = PC_E_RD;
			end
			PC_EXH: begin
				cw.wait_out = 1'b1;
				cw.out_load = 1'b1;
				cw.out_exh  = 1'b1;
				cw.done_set = 1'b1;
				cw.cond     = C_ALWAYS;
				cw.target   = PC_IDLE;
			end
			PC_NEXT: begin
				cw.p_op   = P_KM1;
				cw.cond   = C_DONE;
				cw.target = PC_EXH;
			end
			PC_N_RD: begin
				cw.rd_a_en  = 1'b1;
				cw.rd_a_sel = SEL_P;
				cw.rd_b_en  = 1'b1;
				cw.rd_b_sel = SEL_P1;
				cw.cond     = C_P_ZERO;
				cw.target   = PC_F_INIT;
			end
			PC_N_CMP: begin
				cw.cond   = C_RA_LE_RB;
				cw.target = PC_N_QK;
			end
			PC_N_DEC: begin
				cw.p_op   = P_DEC;
				cw.cond   = C_ALWAYS;
				cw.target = PC_N_RD;
			end
			PC_N_QK: begin
				cw.q_op = Q_K;
			end
			PC_N_QRD: begin
				cw.rd_a_en  = 1'b1;
				cw.rd_a_sel = SEL_Q;
				cw.rd_b_en  = 1'b1;
				cw.rd_b_sel = SEL_P;
			end
			PC_N_QCMP: begin
				cw.cond   = C_RA_LT_RB;
				cw.target = PC_N_QDEC;
			end
			PC_N_SWP0: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_P;
				cw.wr_data_sel = WD_RA;
			end
			PC_N_SWP1: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_Q;
				cw.wr_data_sel = WD_RB;
				cw.p_op        = P_INC;
				cw.q_op        = Q_K;
			end
			PC_R_RD: begin
				cw.rd_a_en  = 1'b1;
				cw.rd_a_sel = SEL_P;
				cw.rd_b_en  = 1'b1;
				cw.rd_b_sel = SEL_Q;
				cw.cond     = C_P_GE_Q;
				cw.target   = PC_EMIT;
			end
			PC_R_WP: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_P;
				cw.wr_data_sel = WD_RB;
			end
			PC_R_WQ: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_Q;
				cw.wr_data_sel = WD_RA;
				cw.p_op        = P_INC;
				cw.q_op        = Q_DEC;
				cw.cond        = C_ALWAYS;
				cw.target      = PC_R_RD;
			end
			PC_N_QDEC: begin
				cw.q_op   = Q_DEC;
				cw.cond   = C_ALWAYS;
				cw.target = PC_N_QRD;
			end
			PC_F_INIT: begin
				cw.p_op = P_ONE;
				cw.q_op = Q_K;
			end
			PC_F_RD: begin
				cw.rd_a_en  = 1'b1;
				cw.rd_a_sel = SEL_P;
				cw.rd_b_en  = 1'b1;
				cw.rd_b_sel = SEL_Q;
				cw.cond     = C_P_GE_Q;
				cw.target   = PC_COMB;
			end
			PC_F_WP: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_P;
				cw.wr_data_sel = WD_RB;
			end
			PC_F_WQ: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_Q;
				cw.wr_data_sel = WD_RA;
				cw.p_op        = P_INC;
				cw.q_op        = Q_DEC;
				cw.cond        = C_ALWAYS;
				cw.target      = PC_F_RD;
			end
			PC_COMB: begin
				cw.p_op = P_K;
			end
			PC_C_RD: begin
				cw.rd_a_en  = 1'b1;
				cw.rd_a_sel = SEL_P;
				cw.cond     = C_P_ZERO;
				cw.target   = PC_EXH;
			end
			PC_C_CMP: begin
				cw.cond   = C_RA_NE_LIM;
				cw.target = PC_C_BUMP;
			end
			PC_C_DEC: begin
				cw.p_op   = P_DEC;
				cw.cond   = C_ALWAYS;
				cw.target = PC_C_RD;
			end
			PC_C_BUMP: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_P;
				cw.wr_data_sel = WD_RA_INC;
				cw.ra_bump     = 1'b1;
				cw.q_op        = Q_P1;
			end
			PC_C_CHK: begin
				cw.cond   = C_Q_GT_K;
				cw.target = PC_EMIT;
			end
			PC_C_FILL: begin
				cw.wr_en       = 1'b1;
				cw.wr_addr_sel = SEL_Q;
				cw.wr_data_sel = WD_RA_INC;
				cw.ra_bump     = 1'b1;
				cw.q_op        = Q_INC;
				cw.cond        = C_ALWAYS;
				cw.target      = PC_C_CHK;
			end
			default: begin
				cw.cond   = C_ALWAYS;
				cw.target = PC_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/kag_sequencer.sv -----
// kag_sequencer: step counter, branch evaluation and request dispatch.
// Depends on kag_pkg and kag_ucode_rom.
module kag_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic [1:0]           req_type,
	output logic                 req_ready,
	input  kag_pkg::dp_status_t  status,
	output kag_pkg::ctrl_word_t  cw,
	output logic                 go
);
	import kag_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic            taken;

	kag_ucode_rom u_rom (
		.pc (pc_q),
		.cw (cw)
	);

	assign go        = !(cw.wait_out && !status.slot_free);
	assign req_ready = (pc_q == PC_IDLE);

	always_comb begin
		case (cw.cond)
			C_NEVER:     taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_P_NE_K:    taken = !status.p_eq_k;
			C_P_EQ_K:    taken = status.p_eq_k;
			C_DONE:      taken = status.done;
			C_P_ZERO:    taken = status.p_zero;
			C_RA_LE_RB:  taken = !status.ra_gt_rb;
			C_RA_LT_RB:  taken = status.ra_lt_rb;
			C_P_GE_Q:    taken = status.p_ge_q;
			C_RA_NE_LIM: taken = !status.ra_eq_lim;
			C_Q_GT_K:    taken = status.q_gt_k;
			default:     taken = 1'b0;
		endcase
	end

	always_comb begin
		pc_next = pc_q + PC_W'(1);
		if (!go) begin
			pc_next = pc_q;
		end else if (cw.cond == C_DISPATCH) begin
			pc_next = PC_IDLE;
			if (req_valid) begin
				case (req_type)
					REQ_START: pc_next = PC_START;
					REQ_NEXT:  pc_next = PC_NEXT;
					default:   pc_next = PC_IDLE;
				endcase
			end
		end else if (taken) begin
			pc_next = cw.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ----- hdl/kag_datapath.sv -----
// kag_datapath: index memory, data table, pointers, configuration and result register.
// Driven by control words from kag_sequencer; depends on kag_pkg.
module kag_datapath #(
	parameter int MAX_SET    = kag_pkg::MAX_SET_DEF,
	parameter int VALUE_BITS = kag_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kag_pkg::ctrl_word_t             cw,
	input  logic                            go,
	input  logic                            req_fire,
	input  kag_pkg::req_t                   req_data,
	input  logic                            cfg_we,
	input  logic [kag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kag_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            res_ready,
	output logic                            res_valid,
	output kag_pkg::res_t                   res_data,
	output kag_pkg::dp_status_t             status
);
	import kag_pkg::*;

	localparam int AW     = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
	localparam int EW     = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
	localparam int VB_EXT = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;
	localparam int MAX_N_I = (MAX_SET > 31) ? 31 : MAX_SET;
	localparam logic [IDX_W-1:0] MAX_N     = IDX_W'(MAX_N_I);
	localparam logic [IDX_W-1:0] LIMIT_K   = IDX_W'(RESULT_LIMIT);
	localparam logic [EW-1:0]    MAX_SET_W = EW'(MAX_SET);

	logic [IDX_W-1:0]      ia_mem [RESULT_LIMIT];
	logic [VALUE_BITS-1:0] tbl_mem [MAX_SET];

	logic [CFG_W-1:0]      set_size_q;
	logic [CFG_W-1:0]      pick_count_q;
	logic [IDX_W-1:0]      run_n_q;
	logic [IDX_W-1:0]      run_k_q;
	logic                  done_q;
	logic [PTR_W-1:0]      p_q;
	logic [PTR_W-1:0]      q_q;
	logic [IDX_W-1:0]      ra_q;
	logic [IDX_W-1:0]      rb_q;
	logic [VALUE_BITS-1:0] tv_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic [IDX_W-1:0]  n_clamp;
	logic [IDX_W-1:0]  k_clamp;
	logic [PTR_W-1:0]  p_plus1;
	logic [PTR_W-1:0]  p_minus1;
	logic [IDX_W-1:0]  lim;
	logic [PTR_W-1:0]  rd_a_ptr;
	logic [PTR_W-1:0]  rd_b_ptr;
	logic [PTR_W-1:0]  wr_ptr;
	logic [IDX_W-1:0]  wr_val;
	logic [IDX_W-1:0]  ra_inc;
	logic [EW-1:0]     li_w;
	logic [EW-1:0]     li_m1;
	logic [EW-1:0]     ra_m1;
	logic              load_ok;
	logic [VB_EXT-1:0] lv_ext;
	logic [VB_EXT-1:0] tv_ext;
	logic              slot_free;

	function automatic logic [PTR_W-1:0] pick_ptr(input logic [1:0] sel,
		input logic [PTR_W-1:0] p, input logic [PTR_W-1:0] q,
		input logic [PTR_W-1:0] p1);
		case (sel)
			SEL_P:   return p;
			SEL_Q:   return q;
			SEL_P1:  return p1;
			default: return p;
		endcase
	endfunction

	always_comb begin
		if (set_size_q == '0) begin
			n_clamp = IDX_W'(1);
		end else if (set_size_q > MAX_N) begin
			n_clamp = MAX_N;
		end else begin
			n_clamp = set_size_q;
		end
		if (pick_count_q == '0) begin
			k_clamp = IDX_W'(1);
		end else if (pick_count_q > n_clamp) begin
			k_clamp = n_clamp;
		end else begin
			k_clamp = pick_count_q;
		end
		if (k_clamp > LIMIT_K) begin
			k_clamp = LIMIT_K;
		end
	end

	assign p_plus1  = p_q + PTR_W'(1);
	assign p_minus1 = p_q - PTR_W'(1);
	assign lim      = run_n_q - run_k_q + p_q;
	assign ra_inc   = ra_q + IDX_W'(1);
	assign rd_a_ptr = pick_ptr(cw.rd_a_sel, p_q, q_q, p_plus1);
	assign rd_b_ptr = pick_ptr(cw.rd_b_sel, p_q, q_q, p_plus1);
	assign wr_ptr   = pick_ptr(cw.wr_addr_sel, p_q, q_q, p_plus1);

	always_comb begin
		case (cw.wr_data_sel)
			WD_P:      wr_val = p_q;
			WD_RA:     wr_val = ra_q;
			WD_RB:     wr_val = rb_q;
			WD_RA_INC: wr_val = ra_inc;
			default:   wr_val = p_q;
		endcase
	end

	assign li_w    = EW'(req_data.load_index);
	assign li_m1   = li_w - EW'(1);
	assign ra_m1   = EW'(ra_q) - EW'(1);
	assign load_ok = (li_w != '0) && (li_w <= MAX_SET_W);
	assign lv_ext  = VB_EXT'(req_data.load_value);
	assign tv_ext  = VB_EXT'(tv_q);

	assign slot_free = !res_valid_q || res_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q   <= SET_SIZE_RST;
			pick_count_q <= PICK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_SIZE:   set_size_q   <= cfg_data;
				CFG_PICK_COUNT: pick_count_q <= cfg_data;
				default:        set_size_q   <= set_size_q;
			endcase
		end
	end

	// run control and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_n_q <= IDX_W'(1);
			run_k_q <= IDX_W'(1);
			done_q  <= 1'b1;
			p_q     <= '0;
			q_q     <= '0;
		end else if (go) begin
			if (cw.run_load) begin
				run_n_q <= n_clamp;
				run_k_q <= k_clamp;
			end
			if (cw.done_clr) begin
				done_q <= 1'b0;
			end else if (cw.done_set) begin
				done_q <= 1'b1;
			end
			case (cw.p_op)
				P_ONE:   p_q <= PTR_W'(1);
				P_KM1:   p_q <= run_k_q - PTR_W'(1);
				P_K:     p_q <= run_k_q;
				P_INC:   p_q <= p_plus1;
				P_DEC:   p_q <= p_minus1;
				default: p_q <= p_q;
			endcase
			case (cw.q_op)
				Q_K:     q_q <= run_k_q;
				Q_P1:    q_q <= p_plus1;
				Q_INC:   q_q <= q_q + PTR_W'(1);
				Q_DEC:   q_q <= q_q - PTR_W'(1);
				default: q_q <= q_q;
			endcase
		end
	end

	// index memory: two registered read ports, one write port
	always_ff @(posedge clk) begin
		if (go && cw.wr_en) begin
			ia_mem[ptr_addr(wr_ptr)] <= wr_val;
		end
		if (go && cw.rd_a_en) begin
			ra_q <= ia_mem[ptr_addr(rd_a_ptr)];
		end else if (go && cw.ra_bump) begin
			ra_q <= ra_inc;
		end
		if (go && cw.rd_b_en) begin
			rb_q <= ia_mem[ptr_addr(rd_b_ptr)];
		end
	end

	// data table
	always_ff @(posedge clk) begin
		if (req_fire && (req_data.req_type == REQ_LOAD) && load_ok) begin
			tbl_mem[li_m1[AW-1:0]] <= lv_ext[VALUE_BITS-1:0];
		end
		if (go && cw.tbl_rd) begin
			tv_q <= tbl_mem[ra_m1[AW-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && cw.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.out_load) begin
			if (cw.out_exh) begin
				res_q <= '{position: '0, element_index: '0, element_value: '0,
					last: 1'b1, exhausted: 1'b1};
			end else begin
				res_q <= '{position: p_minus1[POS_W-1:0], element_index: ra_q,
					element_value: tv_ext[VAL_W-1:0], last: (p_q == run_k_q),
					exhausted: 1'b0};
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign status = '{
		done:      done_q,
		slot_free: slot_free,
		p_eq_k:    (p_q == run_k_q),
		p_zero:    (p_q == '0),
		ra_gt_rb:  (ra_q > rb_q),
		ra_lt_rb:  (ra_q < rb_q),
		p_ge_q:    (p_q >= q_q),
		ra_eq_lim: (ra_q == lim),
		q_gt_k:    (q_q > run_k_q)
	};

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		p_q <= PTR_W'(RESULT_LIMIT + 1))
		else $error("index pointer beyond arrangement length");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(go && cw.wr_en) |-> ((wr_ptr != '0) && (wr_ptr <= run_k_q)))
		else $error("index memory write outside active positions");

	a_no_sel_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(go && cw.out_load && !cw.out_exh) |-> !done_q)
		else $error("selection emitted after enumeration ended");

endmodule

// ----- hdl/k_arrangement_generator.sv -----
// k_arrangement_generator: one request at a time; one control word per cycle, stalled while
// a result is due and the last is not yet taken. A start fills the index memory and emits
// the first arrangement. A next runs the pivot scan, the reverse and the combination refill
// over the single index memory write port; a next that ends the run gives the exhausted
// result. Reset clears control state, sets the exhausted flag, set_size 5 and pick_count 3;
// index memory and data table are not cleared.
module k_arrangement_generator #(
	parameter int MAX_SET    = kag_pkg::MAX_SET_DEF,
	parameter int VALUE_BITS = kag_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  kag_pkg::req_t                 req_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output kag_pkg::res_t                 res_data,
	input  logic                          cfg_we,
	input  logic [kag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kag_pkg::CFG_W-1:0]     cfg_data
);
	import kag_pkg::*;

	ctrl_word_t cw;
	dp_status_t status;
	logic       go;
	logic       req_fire;

	assign req_fire = req_valid && req_ready;

	kag_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_ready (req_ready),
		.status    (status),
		.cw        (cw),
		.go        (go)
	);

	kag_datapath #(
		.MAX_SET    (MAX_SET),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.go        (go),
		.req_fire  (req_fire),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_data  (res_data),
		.status    (status)
	);

endmodule

// ----- tb/sv/k_arrangement_generator_tb.sv -----
// k_arrangement_generator_tb: self-checking testbench for the k-arrangement generator.
// Predicts every result of load, start and next requests with its own copy of the state.
// Depends on kag_pkg and k_arrangement_generator under hdl.
`timescale 1ns / 100ps

module k_arrangement_generator_tb;
	import kag_pkg::*;

	localparam logic [1:0] REQ_RSVD      = 2'd3;
	localparam int         SETTLE_CYCLES = 300;
	localparam int         CYCLE_LIMIT   = 3_000_000;
	localparam int         RANDOM_ITEMS  = 480;
	localparam int         PRINT_CAP     = 50;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req_data = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// predictor state
	logic [IDX_W-1:0] sel_idx [0:MAX_SET_DEF];
	logic [VAL_W-1:0] elem_tbl [0:MAX_SET_DEF];
	logic             run_over = 1'b1;
	logic [CFG_W-1:0] cfg_set = SET_SIZE_RST;
	logic [CFG_W-1:0] cfg_pick = PICK_COUNT_RST;
	int               run_n = 1;
	int               run_k = 1;

	res_t arrangement_q [$];
	int   err_count = 0;
	int   cycle_count = 0;
	int   idle_pct = 16;
	int   work_items = 0;

	k_arrangement_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic flag_mismatch(input string msg);
		if (err_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (arrangement_q.size() == 0) begin
				flag_mismatch($sformatf("result %h with nothing pending", res_data));
			end else begin
				want = arrangement_q.pop_front();
				if (res_data.position !== want.position)
					flag_mismatch($sformatf("position %0d, want %0d",
						res_data.position, want.position));
				if (res_data.element_index !== want.element_index)
					flag_mismatch($sformatf("element_index %0d, want %0d",
						res_data.element_index, want.element_index));
				if (res_data.element_value !== want.element_value)
					flag_mismatch($sformatf("element_value %0d, want %0d",
						res_data.element_value, want.element_value));
				if (res_data.last !== want.last)
					flag_mismatch($sformatf("last %b, want %b", res_data.last, want.last));
				if (res_data.exhausted !== want.exhausted)
					flag_mismatch($sformatf("exhausted %b, want %b",
						res_data.exhausted, want.exhausted));
			end
		end
	end

	function automatic void clamp_cfg(output int n, output int k);
		n = cfg_set;
		k = cfg_pick;
		if (n < 1) n = 1;
		if (n > MAX_SET_DEF) n = MAX_SET_DEF;
		if (k < 1) k = 1;
		if (k > n) k = n;
		if (k > RESULT_LIMIT) k = RESULT_LIMIT;
	endfunction

	function automatic void swap_sel(input int a, input int b);
		logic [IDX_W-1:0] t;
		t = sel_idx[a];
		sel_idx[a] = sel_idx[b];
		sel_idx[b] = t;
	endfunction

	function automatic void flip_sel(input int lo, input int hi);
		while (lo < hi) begin
			swap_sel(lo, hi);
			lo++;
			hi--;
		end
	endfunction

	function automatic bit next_permutation();
		int p;
		int q;
		p = run_k - 1;
		while (p > 0 && sel_idx[p] > sel_idx[p+1]) p--;
		if (p == 0) return 1'b0;
		q = run_k;
		while (q > p && sel_idx[q] < sel_idx[p]) q--;
		swap_sel(p, q);
		flip_sel(p + 1, run_k);
		return 1'b1;
	endfunction

	function automatic bit next_combination();
		int p;
		int j;
		p = run_k;
		while (p > 0 && int'(sel_idx[p]) == run_n - run_k + p) p--;
		if (p == 0) return 1'b0;
		sel_idx[p] = sel_idx[p] + 1'b1;
		for (j = p + 1; j <= run_k; j++) sel_idx[j] = sel_idx[j-1] + 1'b1;
		return 1'b1;
	endfunction

	function automatic void push_arrangement();
		res_t r;
		int pos;
		for (pos = 0; pos < run_k; pos++) begin
			r.position      = POS_W'(pos);
			r.element_index = sel_idx[pos+1];
			r.element_value = elem_tbl[sel_idx[pos+1]];
			r.last          = (pos + 1 == run_k);
			r.exhausted     = 1'b0;
			arrangement_q.push_back(r);
		end
	endfunction

	function automatic void push_exhausted();
		res_t r;
		r = '0;
		r.last = 1'b1;
		r.exhausted = 1'b1;
		arrangement_q.push_back(r);
	endfunction

	function automatic void arrange_step(input req_t r);
		int j;
		case (r.req_type)
			REQ_LOAD: begin
				if (r.load_index >= 1 && r.load_index <= MAX_SET_DEF)
					elem_tbl[r.load_index] = r.load_value;
			end
			REQ_START: begin
				clamp_cfg(run_n, run_k);
				for (j = 1; j <= run_k; j++) sel_idx[j] = IDX_W'(j);
				run_over = 1'b0;
				push_arrangement();
			end
			REQ_NEXT: begin
				if (run_over) begin
					push_exhausted();
				end else if (next_permutation()) begin
					push_arrangement();
				end else begin
					flip_sel(1, run_k);
					if (next_combination()) begin
						push_arrangement();
					end else begin
						run_over = 1'b1;
						push_exhausted();
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic req_t make_req(input logic [1:0] kind, input int idx, input int val);
		req_t r;
		r.req_type   = kind;
		r.load_index = IDX_W'(idx);
		r.load_value = VAL_W'(val);
		return r;
	endfunction

	function automatic int arrangement_count(input int n, input int k);
		int c;
		int j;
		c = 1;
		for (j = 0; j < k; j++) begin
			c = c * (n - j);
			if (c > 1000) return 1000;
		end
		return c;
	endfunction

	// hold valid high after acceptance; the next call or settle drops or reloads it
	task automatic send_req(input req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		arrange_step(r);
		if (r.req_type != REQ_RSVD &&
				!(r.req_type == REQ_LOAD && (r.load_index < 1 || r.load_index > MAX_SET_DEF)))
			work_items++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (arrangement_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		if (idx == CFG_SET_SIZE) cfg_set = CFG_W'(val);
		else cfg_pick = CFG_W'(val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic t_before_start();
		send_req(make_req(REQ_NEXT, 31, 255));
		send_req(make_req(REQ_RSVD, 31, 255));
		settle();
	endtask

	task automatic t_table_load();
		int j;
		for (j = 1; j <= MAX_SET_DEF; j++)
			send_req(make_req(REQ_LOAD, j,
				(j == 1) ? 0 : (j == MAX_SET_DEF) ? 255 : $urandom_range(255)));
		send_req(make_req(REQ_LOAD, 0, 170));
		send_req(make_req(REQ_LOAD, 31, 85));
		settle();
	endtask

	task automatic t_reset_config();
		send_req(make_req(REQ_START, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		settle();
	endtask

	task automatic t_config_extremes();
		cfg_write(CFG_SET_SIZE, 1);
		cfg_write(CFG_PICK_COUNT, 1);
		send_req(make_req(REQ_START, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		settle();
		cfg_write(CFG_SET_SIZE, 0);
		cfg_write(CFG_PICK_COUNT, 0);
		send_req(make_req(REQ_START, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		settle();
		cfg_write(CFG_SET_SIZE, 31);
		cfg_write(CFG_PICK_COUNT, 31);
		send_req(make_req(REQ_START, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		settle();
		cfg_write(CFG_SET_SIZE, 2);
		cfg_write(CFG_PICK_COUNT, 2);
		send_req(make_req(REQ_START, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		send_req(make_req(REQ_NEXT, 0, 0));
		settle();
	endtask

	task automatic t_random_runs();
		int base;
		int n;
		int k;
		int steps;
		int j;
		int r;
		base = work_items;
		while (work_items - base < RANDOM_ITEMS) begin
			idle_pct = (work_items - base >= 150 && work_items - base < 270) ? 0 : 16;
			r = $urandom_range(99);
			if (r < 85) begin
				n = $urandom_range(1, 6);
				k = $urandom_range(0, n + 1);
			end else if (r < 95) begin
				n = $urandom_range(0, 31);
				k = $urandom_range(0, 31);
			end else begin
				n = $urandom_range(7, 16);
				k = $urandom_range(1, 16);
			end
			if ($urandom_range(3) != 0) cfg_write(CFG_SET_SIZE, n);
			if ($urandom_range(3) != 0) cfg_write(CFG_PICK_COUNT, k);
			clamp_cfg(n, k);
			steps = arrangement_count(n, k);
			steps = (steps <= 40) ? steps + $urandom_range(0, 2) : $urandom_range(2, 25);
			if ($urandom_range(19) != 0) send_req(make_req(REQ_START, 0, 0));
			for (j = 0; j < steps; j++) begin
				r = $urandom_range(99);
				if (r < 8) begin
					send_req(make_req(REQ_LOAD, $urandom_range(1, 16), $urandom_range(255)));
				end else if (r < 10) begin
					send_req(make_req(REQ_RSVD, $urandom_range(31), $urandom_range(255)));
				end else if (r < 12) begin
					send_req(make_req(REQ_LOAD, ($urandom_range(1) != 0) ? 0 :
						$urandom_range(17, 31), $urandom_range(255)));
				end else if (r < 14) begin
					send_req(make_req(REQ_START, $urandom_range(31), $urandom_range(255)));
				end else if (r < 16) begin
					// change registers mid-run; the running enumeration keeps its sizes
					settle();
					cfg_write(CFG_SET_SIZE, $urandom_range(0, 31));
					cfg_write(CFG_PICK_COUNT, $urandom_range(0, 31));
				end else begin
					send_req(make_req(REQ_NEXT, $urandom_range(31), $urandom_range(255)));
				end
			end
			settle();
		end
		idle_pct = 16;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		t_before_start();
		t_table_load();
		t_reset_config();
		t_config_extremes();
		t_random_runs();
		settle();
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/kag_pkg.sv
hdl/kag_ucode_rom.sv
hdl/kag_sequencer.sv
hdl/kag_datapath.sv
hdl/k_arrangement_generator.sv
tb/sv/k_arrangement_generator_tb.sv
